// File: hdl/png_chunk_stream_parser_unit_macros.svh
// Assertion macros shared by the parser's checker.
`ifndef PNG_CHUNK_STREAM_PARSER_UNIT_MACROS_SVH
`define PNG_CHUNK_STREAM_PARSER_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PCSP_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Same, with the block's usual clock and reset names.
`define PCSP_ASSERT(lbl, prop, msg) \
	`PCSP_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// File: hdl/pcsp_pkg.sv
// Types, codes and header check function for the PNG chunk stream parser.
`default_nettype none
package pcsp_pkg;

	typedef enum logic [3:0] {
		PH_SIG       = 4'd0,
		PH_IHDR_LEN  = 4'd1,
		PH_IHDR_TYPE = 4'd2,
		PH_IHDR_DATA = 4'd3,
		PH_IHDR_CRC  = 4'd4,
		PH_CH_LEN    = 4'd5,
		PH_CH_TYPE   = 4'd6,
		PH_SKIP      = 4'd7,
		PH_DATA      = 4'd8,
		PH_CRC       = 4'd9,
		PH_END_CRC   = 4'd10,
		PH_HALT      = 4'd11
	} phase_t;

	typedef logic [3:0] status_t;

	localparam status_t ST_BUSY         = 4'd0;
	localparam status_t ST_DONE         = 4'd1;
	localparam status_t ST_BAD_SIG      = 4'd2;
	localparam status_t ST_BAD_FIRST    = 4'd3;
	localparam status_t ST_BAD_DEPTH    = 4'd4;
	localparam status_t ST_BAD_COLOUR   = 4'd5;
	localparam status_t ST_BAD_COMBO    = 4'd6;
	localparam status_t ST_BAD_COMP     = 4'd7;
	localparam status_t ST_BAD_FILTER   = 4'd8;
	localparam status_t ST_BAD_INTERL   = 4'd9;
	localparam status_t ST_UNSUP_FMT    = 4'd10;
	localparam status_t ST_UNSUP_INTERL = 4'd11;
	localparam status_t ST_UNSUP_CRIT   = 4'd12;
	localparam status_t ST_BAD_IEND     = 4'd13;

	localparam int unsigned SIG_LEN = 8;
	localparam int unsigned IHDR_LEN = 13;
	localparam logic [7:0] MAX_DEPTH = 8'd16;

	localparam logic [7:0] PNG_SIG [SIG_LEN] = '{
		8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
	};

	localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
	localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
	localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7A;

	typedef struct packed {
		logic          payload_valid;
		logic [7:0]    payload_byte;
		status_t       status;
		logic [30:0]   image_width;
		logic [30:0]   image_height;
	} result_t;

	// IHDR field validation; first failing check wins, ST_BUSY means accepted.
	function automatic status_t check_header(input logic [7:0] depth,
		input logic [7:0] colour, input logic [7:0] comp,
		input logic [7:0] filt, input logic [7:0] inter);
		status_t code;
		logic    pow2;
		pow2 = (depth != 8'd0) && (((depth - 8'd1) & depth) == 8'd0);
		if (!pow2 || depth > MAX_DEPTH)
			code = ST_BAD_DEPTH;
		else if ((colour != 8'd3 && colour[0]) || colour > 8'd6)
			code = ST_BAD_COLOUR;
		else if ((depth == MAX_DEPTH && colour == 8'd3) ||
			(depth < 8'd8 && colour != 8'd0 && colour != 8'd3))
			code = ST_BAD_COMBO;
		else if (comp != 8'd0)
			code = ST_BAD_COMP;
		else if (filt != 8'd0)
			code = ST_BAD_FILTER;
		else if (inter != 8'd0 && inter != 8'd1)
			code = ST_BAD_INTERL;
		else if (depth != 8'd8 || colour != 8'd2)
			code = ST_UNSUP_FMT;
		else if (inter != 8'd0)
			code = ST_UNSUP_INTERL;
		else
			code = ST_BUSY;
		return code;
	endfunction

endpackage
`default_nettype wire

// File: hdl/png_chunk_stream_parser_unit.sv
// An input transaction reaches the m_ side via the input and result registers.
// Throughput: one byte per cycle while m_tready allows, no stall of its own;
// the input register feeds parser state machine and result register in one pass.
// Reset (arst_n low): valid flags cleared, parser back to the signature phase,
// status busy, width and height zero. A first_byte resets parser state alike.
`default_nettype none
module png_chunk_stream_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_tuser,   // [0] first_byte
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // [7:0] payload_byte, [11:8] status,
	                                    // [42:12] image_width,
	                                    // [73:43] image_height, [79:74] zero
	output logic [0:0]       m_tuser    // [0] payload_valid
);
	import pcsp_pkg::*;

	logic        v_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic        out_v_q;
	result_t     out_q;
	result_t     res;
	logic        advance;
	logic        step_en;

	// Result register empties or is drained this cycle -> stage 1 moves on.
	assign advance  = !out_v_q || m_tready;
	assign step_en  = v_s1 && advance;
	assign s_tready = !v_s1 || advance;

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1  <= s_tdata;
			first_s1 <= s_tuser[0];
		end
	end

	// Parser state advances once per byte that leaves stage 1.
	pcsp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.res        (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_q <= res;
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tuser[0] = out_q.payload_valid;
	assign m_tdata    = {6'd0, out_q.image_height, out_q.image_width, out_q.status,
		out_q.payload_byte};

endmodule
`default_nettype wire

// File: hdl/pcsp_core.sv
// Parser state machine: per-byte phase walk, header capture and status.
`default_nettype none
module pcsp_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire logic [7:0]        data_byte,
	input  wire logic              first_byte,
	output pcsp_pkg::result_t      res
);
	import pcsp_pkg::*;

	phase_t      phase_q, phase_d, cur_phase;
	logic [31:0] fc_q, fc_d, cur_fc, fc_inc;
	logic [31:0] len_q, len_d, cur_len;
	logic [31:0] type_q, type_d, cur_type, shift_type;
	logic [31:0] wid_q, wid_d, cur_wid;
	logic [31:0] hgt_q, hgt_d, cur_hgt;
	logic [7:0]  hdr_q [5];
	logic [7:0]  hdr_d [5];
	logic [7:0]  cur_hdr [5];
	status_t     st_q, st_d, hdr_code;
	logic        emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			fc_q    <= '0;
			len_q   <= '0;
			type_q  <= '0;
			wid_q   <= '0;
			hgt_q   <= '0;
			st_q    <= ST_BUSY;
			for (int i = 0; i < 5; i++) hdr_q[i] <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			fc_q    <= fc_d;
			len_q   <= len_d;
			type_q  <= type_d;
			wid_q   <= wid_d;
			hgt_q   <= hgt_d;
			st_q    <= st_d;
			for (int i = 0; i < 5; i++) hdr_q[i] <= hdr_d[i];
		end
	end

	// A first byte restarts from the reset image before it is parsed.
	always_comb begin
		cur_phase = first_byte ? PH_SIG : phase_q;
		cur_fc    = first_byte ? 32'd0 : fc_q;
		cur_len   = first_byte ? 32'd0 : len_q;
		cur_type  = first_byte ? 32'd0 : type_q;
		cur_wid   = first_byte ? 32'd0 : wid_q;
		cur_hgt   = first_byte ? 32'd0 : hgt_q;
		for (int i = 0; i < 5; i++) cur_hdr[i] = first_byte ? 8'd0 : hdr_q[i];
	end

	assign fc_inc     = cur_fc + 32'd1;
	assign shift_type = {cur_type[23:0], data_byte};
	assign hdr_code   = check_header(cur_hdr[0], cur_hdr[1], cur_hdr[2], cur_hdr[3],
		cur_hdr[4]);

	always_comb begin
		phase_d = cur_phase;
		fc_d    = fc_inc;
		len_d   = cur_len;
		type_d  = cur_type;
		wid_d   = cur_wid;
		hgt_d   = cur_hgt;
		st_d    = first_byte ? ST_BUSY : st_q;
		for (int i = 0; i < 5; i++) hdr_d[i] = cur_hdr[i];
		emit    = 1'b0;

		unique case (cur_phase)
			PH_SIG: begin
				if (data_byte != PNG_SIG[cur_fc[2:0]]) begin
					st_d    = ST_BAD_SIG;
					phase_d = PH_HALT;
					fc_d    = '0;
				end else if (fc_inc == 32'(SIG_LEN)) begin
					phase_d = PH_IHDR_LEN;
					fc_d    = '0;
				end
			end
			PH_IHDR_LEN, PH_CH_LEN: begin
				len_d = {cur_len[23:0], data_byte};
				if (fc_inc == 32'd4) begin
					phase_d = (cur_phase == PH_IHDR_LEN) ? PH_IHDR_TYPE : PH_CH_TYPE;
					fc_d    = '0;
				end
			end
			PH_IHDR_TYPE: begin
				type_d = shift_type;
				if (fc_inc == 32'd4) begin
					fc_d = '0;
					if (shift_type != TYPE_IHDR || cur_len != 32'(IHDR_LEN)) begin
						st_d    = ST_BAD_FIRST;
						phase_d = PH_HALT;
					end else begin
						phase_d = PH_IHDR_DATA;
					end
				end
			end
			PH_IHDR_DATA: begin
				if (cur_fc < 32'd4)
					wid_d = {cur_wid[23:0], data_byte};
				else if (cur_fc < 32'd8)
					hgt_d = {cur_hgt[23:0], data_byte};
				else if (cur_fc < 32'(IHDR_LEN)) begin
					for (int i = 0; i < 5; i++)
						if (cur_fc[2:0] == 3'(i)) hdr_d[i] = data_byte;
				end
				if (fc_inc >= 32'(IHDR_LEN)) begin
					phase_d = PH_IHDR_CRC;
					fc_d    = '0;
				end
			end
			PH_IHDR_CRC: begin
				if (fc_inc == 32'd4) begin
					fc_d = '0;
					if (hdr_code != ST_BUSY) begin
						st_d    = hdr_code;
						phase_d = PH_HALT;
					end else begin
						phase_d = PH_CH_LEN;
					end
				end
			end
			PH_CH_TYPE: begin
				type_d = shift_type;
				if (fc_inc == 32'd4) begin
					fc_d = '0;
					if (shift_type == TYPE_IEND)
						phase_d = PH_END_CRC;
					else if (shift_type[31:24] >= LOWER_A && shift_type[31:24] <= LOWER_Z)
						phase_d = (cur_len == 32'd0) ? PH_CRC : PH_SKIP;
					else if (shift_type == TYPE_IDAT)
						phase_d = (cur_len == 32'd0) ? PH_CRC : PH_DATA;
					else begin
						st_d    = ST_UNSUP_CRIT;
						phase_d = PH_HALT;
					end
				end
			end
			PH_SKIP, PH_DATA: begin
				emit = (cur_phase == PH_DATA);
				if (fc_inc == cur_len) begin
					phase_d = PH_CRC;
					fc_d    = '0;
				end
			end
			PH_CRC: begin
				if (fc_inc == 32'd4) begin
					phase_d = PH_CH_LEN;
					fc_d    = '0;
				end
			end
			PH_END_CRC: begin
				if (fc_inc == 32'd4) begin
					st_d    = (cur_len != 32'd0) ? ST_BAD_IEND : ST_DONE;
					phase_d = PH_HALT;
					fc_d    = '0;
				end
			end
			default: begin
				fc_d = cur_fc;
			end
		endcase
	end

	assign res.payload_valid = emit;
	assign res.payload_byte  = emit ? data_byte : 8'd0;
	assign res.status        = st_d;
	assign res.image_width   = wid_d[30:0];
	assign res.image_height  = hgt_d[30:0];

endmodule
`default_nettype wire

// File: hdl/pcsp_checker.sv
// Port-level checker for the PNG chunk stream parser, bound to the top level.
`default_nettype none
`include "png_chunk_stream_parser_unit_macros.svh"
module pcsp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata,
	input wire logic [0:0]  m_tuser
);
	import pcsp_pkg::*;

	logic in_xfer;

	assign in_xfer = s_tvalid && s_tready;

	// Stalled result must not change.
	property p_hold;
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
	endproperty

	// Payload bytes only while the parse is still running.
	property p_payload_busy;
		m_tvalid && m_tuser[0] |-> m_tdata[11:8] == ST_BUSY;
	endproperty

	// Non-payload results carry a zero data byte.
	property p_payload_zero;
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0;
	endproperty

	// Status code range and zero padding.
	property p_status_range;
		m_tvalid |-> m_tdata[11:8] <= ST_BAD_IEND && m_tdata[79:74] == 6'd0;
	endproperty

	// No result appears from nothing: a new result follows an input transaction.
	property p_no_phantom;
		$rose(m_tvalid) |-> $past(in_xfer, 1) || $past(in_xfer, 2) || $past(in_xfer, 3);
	endproperty

	`PCSP_ASSERT(a_hold, p_hold, "result changed while stalled")
	`PCSP_ASSERT(a_payload_busy, p_payload_busy, "payload with final status")
	`PCSP_ASSERT(a_payload_zero, p_payload_zero, "stray payload byte")
	`PCSP_ASSERT(a_status_range, p_status_range, "bad status or padding")
	`PCSP_ASSERT(a_no_phantom, p_no_phantom, "result without input")
endmodule

bind png_chunk_stream_parser_unit pcsp_checker u_pcsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// File: bench/tb_png_chunk_stream_parser_unit.sv
// Testbench for png_chunk_stream_parser_unit: PNG byte streams in, per-byte results checked.
`timescale 1ns / 1ps
module tb_png_chunk_stream_parser_unit;
	import pcsp_pkg::*;

	// ---------------------------------------------------------------- bench setup
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the pipe
	localparam int PHASE_BYTES = 125;   // byte budget per idling phase

	// Header combos that pass the depth/colour/combination checks.
	// Entry 5 is the only supported one (8-bit truecolour).
	localparam logic [7:0] LEGAL_DEPTH  [11] = '{8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd8,
		8'd16, 8'd8, 8'd4, 8'd8, 8'd16};
	localparam logic [7:0] LEGAL_COLOUR [11] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2,
		8'd2, 8'd3, 8'd3, 8'd6, 8'd4};
	// Depths that are zero, not a power of two, or above 16.
	localparam logic [7:0] ODD_DEPTH    [9]  = '{8'd0, 8'd3, 8'd5, 8'd6, 8'd12, 8'd17,
		8'd32, 8'd128, 8'd255};
	// Colour types that are odd (other than palette) or above 6.
	localparam logic [7:0] ODD_COLOUR   [6]  = '{8'd1, 8'd5, 8'd7, 8'd9, 8'd200, 8'd255};

	typedef enum {
		F_GOOD,       // well-formed file ending in IEND
		F_BAD_SIG,    // one signature byte corrupted
		F_BAD_FIRST,  // first chunk not IHDR/13
		F_BAD_HDR,    // IHDR fields rejected
		F_BAD_CRIT,   // unknown critical chunk
		F_BAD_IEND,   // IEND with a nonzero length
		F_CUT         // file cut short mid-parse, next file restarts
	} file_kind_t;

	typedef struct packed {
		logic       first;
		logic [7:0] data;
	} file_byte_t;

	// ---------------------------------------------------------------- DUT wiring
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;   // [7:0] data_byte
	logic [0:0]  s_tuser  = 1'b0;   // [0] first_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;           // [7:0] payload_byte, [11:8] status,
	                                // [42:12] image_width, [73:43] image_height
	logic [0:0]  m_tuser;           // [0] payload_valid

	png_chunk_stream_parser_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------- bench state
	file_byte_t file_bytes [$];        // bytes waiting to be offered
	result_t    parser_results_due [$]; // predicted results, oldest first

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int          hold_ask  = 0;        // bumped by the stimulus thread
	int          hold_seen = 0;
	int          hold_left = 0;

	int          error_count     = 0;
	int          bytes_queued    = 0;
	int          bytes_sent      = 0;
	int          files_made      = 0;
	int          results_checked = 0;
	int          idat_bytes_seen = 0;
	logic [15:0] status_seen     = '0;

	// ---------------------------------------------------------------- parser predictor
	// Shadow copy of the parser state, advanced one accepted byte at a time.
	phase_t      ph;
	logic [31:0] cnt;
	logic [31:0] clen;
	logic [31:0] ctype;
	logic [31:0] wreg;
	logic [31:0] hreg;
	logic [7:0]  hdr [5];
	status_t     st;

	function automatic void clear_parse_state();
		ph    = PH_SIG;
		cnt   = '0;
		clen  = '0;
		ctype = '0;
		wreg  = '0;
		hreg  = '0;
		hdr   = '{default: 8'd0};
		st    = ST_BUSY;
	endfunction

	function automatic void move_to(input phase_t p);
		ph  = p;
		cnt = '0;
	endfunction

	function automatic void stop_with(input status_t code);
		st = code;
		move_to(PH_HALT);
	endfunction

	// IHDR field verdict: first failing rule decides, ST_BUSY = accepted.
	function automatic status_t header_verdict();
		logic [7:0] d;
		logic [7:0] c;
		logic [7:0] il;
		status_t    v;
		d  = hdr[0];
		c  = hdr[1];
		il = hdr[4];
		v  = ST_BUSY;
		if (d == 8'd0 || (d & (d - 8'd1)) != 8'd0 || d > MAX_DEPTH)
			v = ST_BAD_DEPTH;
		else if (c > 8'd6 || (c[0] && c != 8'd3))
			v = ST_BAD_COLOUR;
		else if ((d == MAX_DEPTH && c == 8'd3) || (d < 8'd8 && c != 8'd0 && c != 8'd3))
			v = ST_BAD_COMBO;
		else if (hdr[2] != 8'd0)
			v = ST_BAD_COMP;
		else if (hdr[3] != 8'd0)
			v = ST_BAD_FILTER;
		else if (il > 8'd1)
			v = ST_BAD_INTERL;
		else if (d != 8'd8 || c != 8'd2)
			v = ST_UNSUP_FMT;
		else if (il != 8'd0)
			v = ST_UNSUP_INTERL;
		return v;
	endfunction

	// Advance the predictor by one byte and return the result it must produce.
	function automatic result_t parse_byte(input logic [7:0] b, input logic restart);
		result_t r;
		logic    emit;
		status_t v;
		emit = 1'b0;
		if (restart)
			clear_parse_state();
		case (ph)
			PH_SIG: begin
				if (b != PNG_SIG[cnt[2:0]])
					stop_with(ST_BAD_SIG);
				else begin
					cnt++;
					if (cnt == SIG_LEN)
						move_to(PH_IHDR_LEN);
				end
			end
			PH_IHDR_LEN, PH_CH_LEN: begin
				clen = {clen[23:0], b};
				cnt++;
				if (cnt == 4)
					move_to(ph == PH_IHDR_LEN ? PH_IHDR_TYPE : PH_CH_TYPE);
			end
			PH_IHDR_TYPE: begin
				ctype = {ctype[23:0], b};
				cnt++;
				if (cnt == 4) begin
					if (ctype != TYPE_IHDR || clen != IHDR_LEN)
						stop_with(ST_BAD_FIRST);
					else
						move_to(PH_IHDR_DATA);
				end
			end
			PH_IHDR_DATA: begin
				if (cnt < 4)
					wreg = {wreg[23:0], b};
				else if (cnt < 8)
					hreg = {hreg[23:0], b};
				else if (cnt < IHDR_LEN)
					hdr[cnt - 8] = b;
				cnt++;
				if (cnt >= IHDR_LEN)
					move_to(PH_IHDR_CRC);
			end
			PH_IHDR_CRC: begin
				cnt++;
				if (cnt == 4) begin
					v = header_verdict();
					if (v != ST_BUSY)
						stop_with(v);
					else
						move_to(PH_CH_LEN);
				end
			end
			PH_CH_TYPE: begin
				ctype = {ctype[23:0], b};
				cnt++;
				if (cnt == 4) begin
					// IEND first, then ancillary (lowercase lead), then IDAT
					if (ctype == TYPE_IEND)
						move_to(PH_END_CRC);
					else if (ctype[31:24] >= LOWER_A && ctype[31:24] <= LOWER_Z)
						move_to(clen == 0 ? PH_CRC : PH_SKIP);
					else if (ctype == TYPE_IDAT)
						move_to(clen == 0 ? PH_CRC : PH_DATA);
					else
						stop_with(ST_UNSUP_CRIT);
				end
			end
			PH_SKIP, PH_DATA: begin
				emit = (ph == PH_DATA);
				cnt++;
				if (cnt == clen)
					move_to(PH_CRC);
			end
			PH_CRC: begin
				cnt++;
				if (cnt == 4)
					move_to(PH_CH_LEN);
			end
			PH_END_CRC: begin
				cnt++;
				if (cnt == 4) begin
					st = (clen != 0) ? ST_BAD_IEND : ST_DONE;
					move_to(PH_HALT);
				end
			end
			default: ;  // halted: byte ignored, status holds
		endcase
		r.payload_valid = emit;
		r.payload_byte  = emit ? b : 8'd0;
		r.status        = st;
		r.image_width   = wreg[30:0];
		r.image_height  = hreg[30:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus builders
	task automatic put(input logic [7:0] b, input logic first);
		file_byte_t it;
		it.data  = b;
		it.first = first;
		file_bytes.push_back(it);
		bytes_queued++;
	endtask

	task automatic put32(input logic [31:0] v);
		for (int i = 3; i >= 0; i--)
			put(v[8*i +: 8], 1'b0);
	endtask

	// Signature; bad_at >= 0 corrupts that one byte.
	task automatic put_signature(input int bad_at);
		logic [7:0] b;
		for (int i = 0; i < SIG_LEN; i++) begin
			b = PNG_SIG[i];
			if (i == bad_at)
				b = b ^ 8'($urandom_range(1, 255));
			put(b, i == 0);
		end
	endtask

	// Trailing bytes after the parser has stopped; they must be ignored.
	task automatic put_tail_noise();
		repeat ($urandom_range(0, 2))
			put(8'($urandom), 1'b0);
	endtask

	function automatic logic [31:0] pick_dim();
		case ($urandom_range(3))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom;
			default: return $urandom_range(1, 4096);
		endcase
	endfunction

	// IHDR field bytes that should draw the given verdict (ST_BUSY = accepted).
	task automatic header_for(input status_t want, output logic [7:0] d, output logic [7:0] c,
		output logic [7:0] cm, output logic [7:0] fl, output logic [7:0] il);
		int idx;
		idx = $urandom_range(10);
		d  = LEGAL_DEPTH[idx];
		c  = LEGAL_COLOUR[idx];
		cm = 8'd0;
		fl = 8'd0;
		il = 8'd0;
		case (want)
			ST_BAD_DEPTH: begin
				d  = ODD_DEPTH[$urandom_range(8)];
				c  = 8'($urandom);
				cm = 8'($urandom);
				fl = 8'($urandom);
				il = 8'($urandom);
			end
			ST_BAD_COLOUR: begin
				c  = ODD_COLOUR[$urandom_range(5)];
				cm = 8'($urandom);
				fl = 8'($urandom);
				il = 8'($urandom);
			end
			ST_BAD_COMBO: begin
				if ($urandom_range(1)) begin
					d = MAX_DEPTH;
					c = 8'd3;
				end else begin
					d = 8'd1 << $urandom_range(2);
					c = 8'(2 * $urandom_range(1, 3));
				end
				cm = 8'($urandom);
				fl = 8'($urandom);
				il = 8'($urandom);
			end
			ST_BAD_COMP: begin
				cm = 8'($urandom_range(1, 255));
				fl = 8'($urandom);
				il = 8'($urandom);
			end
			ST_BAD_FILTER: begin
				fl = 8'($urandom_range(1, 255));
				il = 8'($urandom);
			end
			ST_BAD_INTERL:
				il = 8'($urandom_range(2, 255));
			ST_UNSUP_FMT: begin
				while (d == 8'd8 && c == 8'd2) begin
					idx = $urandom_range(10);
					d   = LEGAL_DEPTH[idx];
					c   = LEGAL_COLOUR[idx];
				end
				il = 8'($urandom_range(1));
			end
			ST_UNSUP_INTERL: begin
				d  = 8'd8;
				c  = 8'd2;
				il = 8'd1;
			end
			default: begin
				d = 8'd8;
				c = 8'd2;
			end
		endcase
	endtask

	// One file of the given kind; hdr_want only matters for F_BAD_HDR.
	task automatic make_file(input file_kind_t kind, input status_t hdr_want);
		logic [7:0]  d, c, cm, fl, il;
		logic [7:0]  lead;
		logic [31:0] len;
		int          start_sz;
		int          cut;
		files_made++;
		start_sz = file_bytes.size();
		put_signature(kind == F_BAD_SIG ? int'($urandom_range(0, 7)) : -1);
		if (kind == F_BAD_SIG) begin
			put_tail_noise();
			return;
		end
		if (kind == F_BAD_FIRST) begin
			// either a wrong length with the right type, or the right length with any type
			if ($urandom_range(1)) begin
				put32($urandom);
				put32(TYPE_IHDR);
			end else begin
				put32(IHDR_LEN);
				put32($urandom);
			end
			put_tail_noise();
			return;
		end

		header_for(kind == F_BAD_HDR ? hdr_want : ST_BUSY, d, c, cm, fl, il);
		put32(IHDR_LEN);
		put32(TYPE_IHDR);
		put32(pick_dim());
		put32(pick_dim());
		put(d, 1'b0);
		put(c, 1'b0);
		put(cm, 1'b0);
		put(fl, 1'b0);
		put(il, 1'b0);
		put32($urandom);  // CRC, never checked
		if (kind == F_BAD_HDR) begin
			put_tail_noise();
			return;
		end

		if (kind == F_CUT) begin
			// huge ancillary chunk, then the file is chopped anywhere after its first byte
			put32($urandom | 32'h8000_0000);
			put(8'($urandom_range(LOWER_A, LOWER_Z)), 1'b0);
			repeat (3) put(8'($urandom), 1'b0);
			repeat ($urandom_range(0, 10)) put(8'($urandom), 1'b0);
			cut = $urandom_range(1, file_bytes.size() - start_sz);
			while (file_bytes.size() > start_sz + cut) begin
				void'(file_bytes.pop_back());
				bytes_queued--;
			end
			return;
		end

		// body: a mix of IDAT and ancillary chunks, zero-length ones included
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(1)) begin
				len = $urandom_range(0, 12);
				put32(len);
				put32(TYPE_IDAT);
			end else begin
				len = $urandom_range(0, 6);
				put32(len);
				put($urandom_range(0, 3) == 0 ? ($urandom_range(1) ? LOWER_A : LOWER_Z)
					: 8'($urandom_range(LOWER_A, LOWER_Z)), 1'b0);
				repeat (3) put(8'($urandom), 1'b0);
			end
			repeat (len) put(8'($urandom), 1'b0);
			put32($urandom);
		end

		if (kind == F_BAD_CRIT) begin
			// lead byte outside a..z, so the chunk counts as critical
			do
				lead = 8'($urandom);
			while (lead >= LOWER_A && lead <= LOWER_Z);
			put32($urandom_range(0, 20));
			put(lead, 1'b0);
			repeat (3) put(8'($urandom), 1'b0);
			put_tail_noise();
			return;
		end

		put32(kind == F_BAD_IEND ? ($urandom | 32'd1) : 32'd0);
		put32(TYPE_IEND);
		put32($urandom);
		put_tail_noise();
	endtask

	function automatic file_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40)      return F_GOOD;
		else if (r < 50) return F_BAD_IEND;
		else if (r < 68) return F_BAD_HDR;
		else if (r < 78) return F_BAD_CRIT;
		else if (r < 86) return F_CUT;
		else if (r < 93) return F_BAD_FIRST;
		else             return F_BAD_SIG;
	endfunction

	// ---------------------------------------------------------------- driver
	// Offers queued bytes; on each accepted transaction the predictor runs once.
	always @(posedge clk or negedge arst_n) begin : drive
		file_byte_t it;
		result_t    r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'd0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				r = parse_byte(s_tdata, s_tuser[0]);
				parser_results_due.push_back(r);
				bytes_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (file_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					it = file_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= it.data;
					s_tuser  <= it.first;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- receiver
	// Random stalls, plus one long hold-off on request to back up the pipeline.
	always @(posedge clk or negedge arst_n) begin : receive
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ---------------------------------------------------------------- monitor
	task automatic check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : observe
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (parser_results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual user %h data %h",
					$time, m_tuser, m_tdata);
				error_count++;
			end else begin
				want = parser_results_due.pop_front();
				check_field("payload_valid", want.payload_valid, m_tuser[0]);
				check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
				check_field("status", want.status, m_tdata[11:8]);
				check_field("image_width", want.image_width, m_tdata[42:12]);
				check_field("image_height", want.image_height, m_tdata[73:43]);
				check_field("tdata padding", 32'd0, m_tdata[79:74]);
				status_seen[m_tdata[11:8]] = 1'b1;
				if (m_tuser[0])
					idat_bytes_seen++;
				results_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus sequence
	initial begin : stimulus
		int goal;
		clear_parse_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 4; p++) begin
			@(negedge clk);
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase

			// one file of every kind and every header verdict, spread over the phases
			case (p)
				0: begin
					// straight after reset, no restart flag; then data extremes with restarts
					put(8'h00, 1'b0);
					put(8'hFF, 1'b0);
					put(8'hFF, 1'b1);
					put(8'h00, 1'b1);
					make_file(F_GOOD, ST_BUSY);
					make_file(F_BAD_SIG, ST_BUSY);
					make_file(F_BAD_FIRST, ST_BUSY);
					make_file(F_BAD_CRIT, ST_BUSY);
					// receiver goes quiet while the sender keeps pushing
					hold_ask++;
				end
				1: begin
					make_file(F_BAD_IEND, ST_BUSY);
					make_file(F_CUT, ST_BUSY);
					make_file(F_BAD_HDR, ST_BAD_DEPTH);
					make_file(F_BAD_HDR, ST_BAD_COLOUR);
				end
				2: begin
					make_file(F_BAD_HDR, ST_BAD_COMBO);
					make_file(F_BAD_HDR, ST_BAD_COMP);
					make_file(F_BAD_HDR, ST_BAD_FILTER);
				end
				default: begin
					make_file(F_BAD_HDR, ST_BAD_INTERL);
					make_file(F_BAD_HDR, ST_UNSUP_FMT);
					make_file(F_BAD_HDR, ST_UNSUP_INTERL);
				end
			endcase

			// random files top the phase up to its share of the byte budget
			goal = PHASE_BYTES * (p + 1);
			while (bytes_queued < goal)
				make_file(pick_kind(), status_t'($urandom_range(ST_BAD_DEPTH, ST_UNSUP_INTERL)));

			// phase ends once everything is sent and answered
			while (file_bytes.size() != 0 || s_tvalid)
				@(negedge clk);
			while (parser_results_due.size() != 0)
				@(negedge clk);
		end

		// give stray results a chance to show up
		repeat (10) @(negedge clk);
		$display("Run covered %0d byte transactions over %0d files, %0d results checked.",
			bytes_sent, files_made, results_checked);
		$display("IDAT bytes passed through: %0d; status codes seen (bit per code): %b",
			idat_bytes_seen, status_seen);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------- watchdog
	initial begin : watchdog
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/pcsp_pkg.sv
hdl/pcsp_core.sv
hdl/png_chunk_stream_parser_unit.sv
hdl/pcsp_checker.sv
bench/tb_png_chunk_stream_parser_unit.sv
